// ===== rtl/core/mrbt_pkg.sv =====
// ----------------------------------------------------------------------------
// mrbt_pkg: shared types and constants of the main RAM burst timing port
// Size codes, latency constants, reset values and the decoded access word.
// ----------------------------------------------------------------------------
package mrbt_pkg;

  // default widths handed to the top level
  localparam int TIME_BITS_DEF = 64;
  localparam int ADDR_BITS_DEF = 22;

  // access size codes; code three falls in with 32 bit
  localparam logic [1:0] SIZE_B8  = 2'd0;
  localparam logic [1:0] SIZE_B16 = 2'd1;
  localparam logic [1:0] SIZE_B32 = 2'd2;

  // access direction
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // burst limit after reset
  localparam logic [7:0] BURST_LIMIT_RST = 8'd241;

  // chunk position (address bits 4:1) from which a burst counts as late
  localparam logic [3:0] LATE_POS_MIN = 4'hD;

  // latencies in cycles
  typedef logic [2:0] mrbt_lat_t;
  localparam mrbt_lat_t LAT_SEQ        = 3'd1;
  localparam mrbt_lat_t LAT_RD_NARROW  = 3'd4;
  localparam mrbt_lat_t LAT_RD_WIDE    = 3'd5;
  localparam mrbt_lat_t LAT_WR_HALF    = 3'd2;
  localparam mrbt_lat_t LAT_WR_OTHER   = 3'd3;
  localparam mrbt_lat_t GAP_RD_WIDE    = 3'd2;
  localparam mrbt_lat_t BUSY_RD        = 3'd3;
  localparam mrbt_lat_t BUSY_WR_HALF   = 3'd6;
  localparam mrbt_lat_t BUSY_WR_OTHER  = 3'd5;

  // decoded access word
  typedef struct packed {
    logic is_write;
    logic wide;
    logic half;
    logic seq_req;
    logic chunk_start;
    logic late_pos;
  } mrbt_op_t;

endpackage

// ===== rtl/core/main_ram_burst_timing.sv =====
// Pipeline: each word passes the input register, then the result register.
// Throughput: one word per cycle while the result stage is not held by
//   out_ready; the burst state is committed as each word leaves the input
//   stage, and the next word, loaded at that edge, sees the new state.
// Reset: rst_n synchronous, active low; clears the burst state and both
//   pipeline valids, and loads the burst limit with 241.
// ----------------------------------------------------------------------------
// main_ram_burst_timing: main RAM burst timing port
// Input register, one-pass timing datapath with burst state, result register.
// ----------------------------------------------------------------------------
module main_ram_burst_timing import mrbt_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [7:0]           cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_operation,
  input  logic [TIME_BITS-1:0] in_now,
  input  logic [ADDR_BITS-1:0] in_address,
  input  logic [1:0]           in_size,
  input  logic                 in_seq_request,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [TIME_BITS-1:0] out_finish_time,
  output logic                 out_seq_granted
);

  mrbt_op_t             in_op;
  mrbt_op_t             op_r;
  logic [TIME_BITS-1:0] now_r;
  logic                 s1_valid_r;
  logic                 out_valid_r;
  logic [TIME_BITS-1:0] finish_r;
  logic                 seq_r;
  logic                 advance;
  logic [TIME_BITS-1:0] finish_time;
  logic                 seq_granted;

  // decode ahead of the input register
  mrbt_decode #(.ADDR_BITS(ADDR_BITS)) u_decode (
    .operation   (in_operation),
    .address     (in_address),
    .size        (in_size),
    .seq_request (in_seq_request),
    .op          (in_op)
  );

  // handshake
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      op_r  <= in_op;
      now_r <= in_now;
    end
  end

  // timing datapath
  mrbt_timing #(.TIME_BITS(TIME_BITS)) u_timing (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fire        (advance),
    .op          (op_r),
    .now         (now_r),
    .finish_time (finish_time),
    .seq_granted (seq_granted)
  );

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      finish_r <= finish_time;
      seq_r    <= seq_granted;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_finish_time = finish_r;
  assign out_seq_granted = seq_r;

endmodule

// ===== rtl/core/mrbt_decode.sv =====
// ----------------------------------------------------------------------------
// mrbt_decode: access decoder
// Turns the raw input fields into the decoded access word.
// ----------------------------------------------------------------------------
module mrbt_decode import mrbt_pkg::*; #(
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic                 operation,
  input  logic [ADDR_BITS-1:0] address,
  input  logic [1:0]           size,
  input  logic                 seq_request,
  output mrbt_op_t             op
);

  logic [3:0] pos;

  assign pos = address[4:1];

  // field decode: direction, sequential request, chunk position and size
  always_comb begin
    op.is_write    = (operation == OP_WRITE);
    op.seq_req     = seq_request;
    op.chunk_start = (pos == 4'd0);
    op.late_pos    = (pos >= LATE_POS_MIN);
    unique case (size)
      SIZE_B8: begin
        op.wide = 1'b0;
        op.half = 1'b0;
      end
      SIZE_B16: begin
        op.wide = 1'b0;
        op.half = 1'b1;
      end
      SIZE_B32: begin
        op.wide = 1'b1;
        op.half = 1'b0;
      end
      default: begin
        op.wide = 1'b1;
        op.half = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/core/mrbt_timing.sv =====
// ----------------------------------------------------------------------------
// mrbt_timing: burst state and finish time datapath
// Holds the burst state and the limit register, works out the finish time
// and the granted sequential flag of the word in the input stage, and
// commits the state when that word moves on.
// ----------------------------------------------------------------------------
module mrbt_timing import mrbt_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [7:0]           cfg_wr_data,
  input  logic                 fire,
  input  mrbt_op_t             op,
  input  logic [TIME_BITS-1:0] now,
  output logic [TIME_BITS-1:0] finish_time,
  output logic                 seq_granted
);

  logic [7:0]           burst_limit_r;
  logic                 last_was_read_r;
  logic [TIME_BITS-1:0] burst_start_r;
  logic                 late_flag_r;
  logic [TIME_BITS-1:0] last_access_r;
  logic [TIME_BITS-1:0] busy_until_r;

  logic [TIME_BITS-1:0] age;
  logic                 too_long;
  logic                 seq_dir;
  logic [TIME_BITS-1:0] t_start;
  mrbt_lat_t            lat;
  logic [TIME_BITS-1:0] t_lat;
  logic [TIME_BITS-1:0] floor_t;
  mrbt_lat_t            busy_lat;
  logic [TIME_BITS-1:0] busy_until_nxt;

  // sequential grant: same direction, burst young enough, no late wrap
  assign seq_dir     = op.seq_req && (op.is_write != last_was_read_r);
  assign age         = now - burst_start_r;
  assign too_long    = age > TIME_BITS'(burst_limit_r);
  assign seq_granted = seq_dir && !too_long && !(late_flag_r && op.chunk_start);

  // a new burst waits for the RAM to go idle
  assign t_start = (!seq_granted && (now < busy_until_r)) ? busy_until_r : now;

  // access latency
  always_comb begin
    if (seq_granted) begin
      lat = LAT_SEQ;
    end else if (op.is_write) begin
      lat = op.half ? LAT_WR_HALF : LAT_WR_OTHER;
    end else begin
      lat = op.wide ? LAT_RD_WIDE : LAT_RD_NARROW;
    end
  end

  assign t_lat   = t_start + TIME_BITS'(lat);
  assign floor_t = last_access_r + TIME_BITS'(GAP_RD_WIDE);

  // sequential wide reads keep a minimum spacing from the last read
  always_comb begin
    if (seq_granted && !op.is_write && op.wide && (t_lat < floor_t)) begin
      finish_time = floor_t;
    end else begin
      finish_time = t_lat;
    end
  end

  // busy window after the access
  always_comb begin
    if (op.is_write) begin
      busy_lat = op.half ? BUSY_WR_HALF : BUSY_WR_OTHER;
    end else begin
      busy_lat = BUSY_RD;
    end
  end

  assign busy_until_nxt = finish_time + TIME_BITS'(busy_lat);

  // limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      burst_limit_r <= BURST_LIMIT_RST;
    end else if (cfg_wr_en) begin
      burst_limit_r <= cfg_wr_data;
    end
  end

  // burst state commit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_was_read_r <= 1'b0;
      burst_start_r   <= '0;
      late_flag_r     <= 1'b0;
      last_access_r   <= '0;
      busy_until_r    <= '0;
    end else if (fire) begin
      last_was_read_r <= !op.is_write;
      busy_until_r    <= busy_until_nxt;
      if (!seq_granted) begin
        burst_start_r <= t_start;
        late_flag_r   <= op.late_pos;
      end
      if (!op.is_write) begin
        last_access_r <= finish_time;
      end
    end
  end

  // checks
  a_seq_needs_req: assert property (@(posedge clk) disable iff (!rst_n)
    seq_granted |-> op.seq_req)
    else $error("sequential granted without request");

  a_seq_keeps_burst: assert property (@(posedge clk) disable iff (!rst_n)
    fire && seq_granted |=> $stable(burst_start_r) && $stable(late_flag_r))
    else $error("sequential word restarted the burst");

  a_write_keeps_last: assert property (@(posedge clk) disable iff (!rst_n)
    fire && op.is_write |=> $stable(last_access_r))
    else $error("write moved the last read time");

  a_read_sets_last: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !op.is_write |=> last_access_r == $past(finish_time))
    else $error("read did not record its finish time");

  a_dir_tracked: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> last_was_read_r == !$past(op.is_write))
    else $error("direction not tracked");

endmodule
